@@ rtl/qmmt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmmt_pkg
// Shared types and constants for the quad motor mixer with trim.
// ----------------------------------------------------------------------------
package qmmt_pkg;

  localparam int CMD_W     = 16;
  localparam int TRIM_W    = 24;
  localparam int LEVEL_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  // trimmed Q.8 axis value: 16-bit command shifted by 8 plus 24-bit trim
  localparam int AXIS_W    = CMD_W + 9;
  // motor sum: thrust plus up to three axis terms
  localparam int SUM_W     = AXIS_W + 2;
  // sum times unsigned gain (sign bit added to the gain)
  localparam int PROD_W    = SUM_W + GAIN_W + 1;
  // Q.8 sum times Q2.14 gain leaves 22 fraction bits
  localparam int FRAC_W    = 22;

  localparam logic [CFG_W-1:0] GAINS_RESET = 64'h4000_4000_4000_4000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_FORMATION     = 3'd0,
    REG_ROLL_TRIM       = 3'd1,
    REG_PITCH_TRIM      = 3'd2,
    REG_YAW_TRIM        = 3'd3,
    REG_MOTOR_GAINS     = 3'd4,
    REG_IDLE_FLOOR      = 3'd5,
    REG_OVERRIDE_ON     = 3'd6,
    REG_OVERRIDE_LEVELS = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CMD_W-1:0] roll_cmd;
    logic signed [CMD_W-1:0] pitch_cmd;
    logic signed [CMD_W-1:0] yaw_cmd;
    logic [CMD_W-1:0]        thrust_cmd;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] motor1_level;
    logic [LEVEL_W-1:0] motor2_level;
    logic [LEVEL_W-1:0] motor3_level;
    logic [LEVEL_W-1:0] motor4_level;
  } result_t;

  typedef struct packed {
    logic                     x_formation;
    logic signed [TRIM_W-1:0] roll_trim;
    logic signed [TRIM_W-1:0] pitch_trim;
    logic signed [TRIM_W-1:0] yaw_trim;
    logic [CFG_W-1:0]         motor_gains;
    logic [LEVEL_W-1:0]       idle_floor;
    logic                     override_on;
    logic [CFG_W-1:0]         override_levels;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/qmmt_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmmt_cfg_regs
// Configuration register file; always ready, one register per write.
// ----------------------------------------------------------------------------
module qmmt_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [qmmt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [qmmt_pkg::CFG_W-1:0]     cfg_data,
  output qmmt_pkg::cfg_t                      cfg
);
  import qmmt_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_formation     <= 1'b0;
      cfg.roll_trim       <= '0;
      cfg.pitch_trim      <= '0;
      cfg.yaw_trim        <= '0;
      cfg.motor_gains     <= GAINS_RESET;
      cfg.idle_floor      <= '0;
      cfg.override_on     <= 1'b0;
      cfg.override_levels <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_e'(cfg_index))
        REG_X_FORMATION:     cfg.x_formation     <= cfg_data[0];
        REG_ROLL_TRIM:       cfg.roll_trim       <= cfg_data[TRIM_W-1:0];
        REG_PITCH_TRIM:      cfg.pitch_trim      <= cfg_data[TRIM_W-1:0];
        REG_YAW_TRIM:        cfg.yaw_trim        <= cfg_data[TRIM_W-1:0];
        REG_MOTOR_GAINS:     cfg.motor_gains     <= cfg_data;
        REG_IDLE_FLOOR:      cfg.idle_floor      <= cfg_data[LEVEL_W-1:0];
        REG_OVERRIDE_ON:     cfg.override_on     <= cfg_data[0];
        REG_OVERRIDE_LEVELS: cfg.override_levels <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/qmmt_motor_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmmt_motor_scale
// One motor channel: gain multiply, truncate, saturate, raise to idle floor.
// ----------------------------------------------------------------------------
module qmmt_motor_scale (
  input  wire logic signed [qmmt_pkg::SUM_W-1:0] sum_q8,
  input  wire logic [qmmt_pkg::GAIN_W-1:0]       gain,
  input  wire logic [qmmt_pkg::LEVEL_W-1:0]      idle_floor,
  output logic [qmmt_pkg::LEVEL_W-1:0]           level
);
  import qmmt_pkg::*;

  logic signed [GAIN_W:0]   gain_s;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-FRAC_W-1:0] whole;
  logic [LEVEL_W-1:0]       sat;

  assign gain_s = {1'b0, gain};
  assign prod   = sum_q8 * gain_s;
  // a negative product truncates to zero or below, so it clamps to zero
  assign whole  = prod[PROD_W-1:FRAC_W];

  always_comb begin
    if (prod[PROD_W-1]) begin
      sat = '0;
    end else if (|whole[PROD_W-FRAC_W-1:LEVEL_W]) begin
      sat = '1;
    end else begin
      sat = whole[LEVEL_W-1:0];
    end
    level = (sat < idle_floor) ? idle_floor : sat;
  end

endmodule
`default_nettype wire

@@ rtl/quad_motor_mixer_trim_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quad_motor_mixer_trim_top
// Quadcopter motor mixer with trim, per-motor gain, idle floor and override.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the item is taken at a rising
//   edge where start is high and busy is low. busy goes low at the first edge
//   with rst low and stays low, so one item can enter per clock.
//   Result channel: done is high for exactly one cycle and result holds the
//   four motor levels in that cycle. The receiver cannot stall; results must
//   be taken when done is high.
//   Stages: the accepting edge loads the input register, then the result
//   register takes the result. Throughput: one item per cycle, set by the
//   single pass of mix and four parallel gain multipliers between those two
//   registers.
//   Configuration: cfg_valid/cfg_ready write channel, always ready; cfg_index
//   selects the register, cfg_data carries the value. Write only while idle.
//   Reset (synchronous, rst high): drops any item in flight, restores all
//   registers to their defaults (plus mixing, zero trims, unity gains, no
//   floor, override off) and holds busy high until the first edge with rst low.
// ----------------------------------------------------------------------------
module quad_motor_mixer_trim_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire qmmt_pkg::cmd_t                 cmd,
  output logic                                done,
  output qmmt_pkg::result_t                   result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [qmmt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [qmmt_pkg::CFG_W-1:0]     cfg_data
);
  import qmmt_pkg::*;

  cfg_t cfg;

  // input register
  logic in_valid;
  cmd_t cmd_q;

  // trimmed Q.8 axis values
  logic signed [AXIS_W-1:0] roll_q8, pitch_q8, yaw_q8;
  logic signed [AXIS_W-1:0] roll_adj, pitch_adj;
  logic signed [CMD_W-1:0]  roll_half, pitch_half;
  logic signed [SUM_W-1:0]  thr, rr, pp, yy, rh, ph;
  logic signed [SUM_W-1:0]  sum [4];
  logic [LEVEL_W-1:0]       level [4];
  result_t                  result_next;

  qmmt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Hold busy through reset and the cycle after it.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      in_valid <= 1'b0;
    end else begin
      busy     <= 1'b0;
      in_valid <= start && !busy;
    end
  end

  // Capture the command on accept; payload needs no reset.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
    end
  end

  // Command scaled to Q.8 plus trim; the sum always fits the axis width.
  assign roll_q8  = {cmd_q.roll_cmd[CMD_W-1], cmd_q.roll_cmd, 8'h00}
                  + {cfg.roll_trim[TRIM_W-1], cfg.roll_trim};
  assign pitch_q8 = {cmd_q.pitch_cmd[CMD_W-1], cmd_q.pitch_cmd, 8'h00}
                  + {cfg.pitch_trim[TRIM_W-1], cfg.pitch_trim};
  assign yaw_q8   = {cmd_q.yaw_cmd[CMD_W-1], cmd_q.yaw_cmd, 8'h00}
                  + {cfg.yaw_trim[TRIM_W-1], cfg.yaw_trim};

  // X mode: halve and drop the fraction, rounding toward zero. Bias negative
  // values by 511 before the arithmetic shift by 9.
  assign roll_adj   = roll_q8 + AXIS_W'({9{roll_q8[AXIS_W-1]}});
  assign pitch_adj  = pitch_q8 + AXIS_W'({9{pitch_q8[AXIS_W-1]}});
  assign roll_half  = roll_adj[AXIS_W-1:9];
  assign pitch_half = pitch_adj[AXIS_W-1:9];

  assign thr = SUM_W'({1'b0, cmd_q.thrust_cmd, 8'h00});
  assign rr  = SUM_W'(roll_q8);
  assign pp  = SUM_W'(pitch_q8);
  assign yy  = SUM_W'(yaw_q8);
  // sign-extend the halved terms back to Q.8
  assign rh  = SUM_W'($signed({roll_half, 8'h00}));
  assign ph  = SUM_W'($signed({pitch_half, 8'h00}));

  // Mix into the four motor sums.
  always_comb begin
    if (cfg.x_formation) begin
      sum[0] = thr - rh + ph + yy;
      sum[1] = thr - rh - ph - yy;
      sum[2] = thr + rh - ph + yy;
      sum[3] = thr + rh + ph - yy;
    end else begin
      sum[0] = thr + pp + yy;
      sum[1] = thr - rr - yy;
      sum[2] = thr - pp + yy;
      sum[3] = thr + rr - yy;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_motor
    qmmt_motor_scale u_scale (
      .sum_q8     (sum[k]),
      .gain       (cfg.motor_gains[k*GAIN_W +: GAIN_W]),
      .idle_floor (cfg.idle_floor),
      .level      (level[k])
    );
  end

  // Override replaces the whole mix, floor included.
  always_comb begin
    if (cfg.override_on) begin
      result_next.motor1_level = cfg.override_levels[0*LEVEL_W +: LEVEL_W];
      result_next.motor2_level = cfg.override_levels[1*LEVEL_W +: LEVEL_W];
      result_next.motor3_level = cfg.override_levels[2*LEVEL_W +: LEVEL_W];
      result_next.motor4_level = cfg.override_levels[3*LEVEL_W +: LEVEL_W];
    end else begin
      result_next.motor1_level = level[0];
      result_next.motor2_level = level[1];
      result_next.motor3_level = level[2];
      result_next.motor4_level = level[3];
    end
  end

  // Result register: strobe done for one cycle per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/qmmt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmmt_checker
// Port-level checks of item flow through the mixer, bound to the top level.
// ----------------------------------------------------------------------------
module qmmt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // every accepted item yields a result after the input and result registers
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted item produced no result");

  // no result without an accepted item ahead of it in the input register
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  // reset flushes the result stage
  a_reset_flush: assert property (@(posedge clk)
    $fell(rst) |-> !done)
    else $error("result seen right after reset");

endmodule

bind quad_motor_mixer_trim_top qmmt_checker u_qmmt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quad motor mixer with trim. Directed items
// cover plus and X mixing, trim and gain extremes, idle floor and override.
// Random phases then rewrite every register and stream commands with bursty
// start gaps. A shadow mixer predicts each result, and a monitor compares
// every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import qmmt_pkg::*;

  localparam int     HALF_PERIOD     = 5;
  localparam int     RESET_CYCLES    = 12;
  localparam longint CYCLE_LIMIT     = 300000;
  localparam int     RAND_PHASES     = 8;
  localparam int     ITEMS_PER_PHASE = 60;
  localparam int     STREAM_ITEMS    = 40;
  // leave margin before touching registers
  localparam int     SETTLE_CYCLES   = 4;
  localparam int     DRAIN_LIMIT     = 1000;
  localparam longint Q8_ONE          = 256;
  localparam longint HALF_DIV        = 512;
  localparam longint FRAC_DIV        = longint'(1) <<< FRAC_W;
  localparam longint LEVEL_MAX       = 65535;

  typedef enum int {
    SETUP_RANDOM,
    SETUP_LOW,
    SETUP_HIGH
  } setup_kind_e;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  cmd_t                 cmd       = '0;
  logic                 done;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Shadow copy of the register file, updated on each accepted write.
  logic               mix_x;
  logic [TRIM_W-1:0]  trim_roll;
  logic [TRIM_W-1:0]  trim_pitch;
  logic [TRIM_W-1:0]  trim_yaw;
  logic [CFG_W-1:0]   gain_word;
  logic [LEVEL_W-1:0] floor_level;
  logic               override_en;
  logic [CFG_W-1:0]   override_word;

  // Predicted motor levels, oldest first.
  result_t pending_levels[$];

  int     errors       = 0;
  int     cmds_taken   = 0;
  int     writes_taken = 0;
  longint cycles       = 0;

  quad_motor_mixer_trim_top DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Scale one Q.8 motor sum by its Q2.14 gain, truncate toward zero, clamp
  // to the 16-bit range and raise to the idle floor.
  function automatic longint scaled_level(longint sum_q8, logic [GAIN_W-1:0] gain);
    longint lvl;
    lvl = (sum_q8 * longint'(gain)) / FRAC_DIV;
    if (lvl < 0) lvl = 0;
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
    if (lvl < longint'(floor_level)) lvl = longint'(floor_level);
    return lvl;
  endfunction

  // Predict the four motor levels for one command under the shadow setup.
  function automatic result_t mix_levels(cmd_t c);
    longint             roll_q8;
    longint             pitch_q8;
    longint             yaw_q8;
    longint             thrust_q8;
    longint             r_half;
    longint             p_half;
    longint             sums[4];
    logic [LEVEL_W-1:0] lv[4];
    result_t            res;
    if (override_en) begin
      res.motor1_level = override_word[15:0];
      res.motor2_level = override_word[31:16];
      res.motor3_level = override_word[47:32];
      res.motor4_level = override_word[63:48];
      return res;
    end
    roll_q8   = longint'($signed(c.roll_cmd)) * Q8_ONE + longint'($signed(trim_roll));
    pitch_q8  = longint'($signed(c.pitch_cmd)) * Q8_ONE + longint'($signed(trim_pitch));
    yaw_q8    = longint'($signed(c.yaw_cmd)) * Q8_ONE + longint'($signed(trim_yaw));
    thrust_q8 = longint'(c.thrust_cmd) * Q8_ONE;
    if (mix_x) begin
      // halve roll and pitch to whole units, truncating toward zero
      r_half  = (roll_q8 / HALF_DIV) * Q8_ONE;
      p_half  = (pitch_q8 / HALF_DIV) * Q8_ONE;
      sums[0] = thrust_q8 - r_half + p_half + yaw_q8;
      sums[1] = thrust_q8 - r_half - p_half - yaw_q8;
      sums[2] = thrust_q8 + r_half - p_half + yaw_q8;
      sums[3] = thrust_q8 + r_half + p_half - yaw_q8;
    end else begin
      sums[0] = thrust_q8 + pitch_q8 + yaw_q8;
      sums[1] = thrust_q8 - roll_q8 - yaw_q8;
      sums[2] = thrust_q8 - pitch_q8 + yaw_q8;
      sums[3] = thrust_q8 + roll_q8 - yaw_q8;
    end
    for (int k = 0; k < 4; k++) begin
      lv[k] = LEVEL_W'(scaled_level(sums[k], gain_word[GAIN_W*k +: GAIN_W]));
    end
    res.motor1_level = lv[0];
    res.motor2_level = lv[1];
    res.motor3_level = lv[2];
    res.motor4_level = lv[3];
    return res;
  endfunction

  function automatic void check_level(string label, logic [LEVEL_W-1:0] want,
                                      logic [LEVEL_W-1:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, label, want, got);
      errors++;
    end
  endfunction

  // Monitor: everything is sampled at the rising edge, before the DUT's
  // registers update. Check results, log accepted commands, track writes.
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      mix_x         = 1'b0;
      trim_roll     = '0;
      trim_pitch    = '0;
      trim_yaw      = '0;
      gain_word     = GAINS_RESET;
      floor_level   = '0;
      override_en   = 1'b0;
      override_word = '0;
      pending_levels.delete();
    end else begin
      if (done) begin
        if (pending_levels.size() == 0) begin
          $display("%0t unexpected result: expected none, got %h", $time, result);
          errors++;
        end else begin
          want = pending_levels.pop_front();
          check_level("motor1_level", want.motor1_level, result.motor1_level);
          check_level("motor2_level", want.motor2_level, result.motor2_level);
          check_level("motor3_level", want.motor3_level, result.motor3_level);
          check_level("motor4_level", want.motor4_level, result.motor4_level);
        end
      end
      if (start && !busy) begin
        pending_levels.push_back(mix_levels(cmd));
        cmds_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        // drop bits above each register's width, as the block does
        case (cfg_idx_e'(cfg_index))
          REG_X_FORMATION:     mix_x         = cfg_data[0];
          REG_ROLL_TRIM:       trim_roll     = cfg_data[TRIM_W-1:0];
          REG_PITCH_TRIM:      trim_pitch    = cfg_data[TRIM_W-1:0];
          REG_YAW_TRIM:        trim_yaw      = cfg_data[TRIM_W-1:0];
          REG_MOTOR_GAINS:     gain_word     = cfg_data;
          REG_IDLE_FLOOR:      floor_level   = cfg_data[LEVEL_W-1:0];
          REG_OVERRIDE_ON:     override_en   = cfg_data[0];
          REG_OVERRIDE_LEVELS: override_word = cfg_data;
          default: ;
        endcase
        writes_taken++;
      end
    end
  end

  // Watchdog: end the run if anything hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Fill the bits above a register's width with noise; the block must drop them.
  function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] value, int width);
    logic [CFG_W-1:0] mask;
    mask = (width >= CFG_W) ? '1 : ((CFG_W'(1) << width) - 1);
    return (value & mask) | ({$urandom, $urandom} & ~mask);
  endfunction

  // Send one item: idle for gap cycles, then hold start until it is taken.
  // Leave start high on return so a following item can go back to back.
  task automatic send_cmd(cmd_t c, int gap);
    int base;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    base = cmds_taken;
    start <= 1'b1;
    cmd   <= c;
    do @(negedge clk); while (cmds_taken == base);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    int base;
    base = writes_taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (writes_taken == base);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drop start, wait for every predicted result, then let the pipe go quiet.
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_levels.size() != 0) begin
      $display("%0t %0d results never arrived", $time, pending_levels.size());
      errors++;
      pending_levels.delete();
    end
  endtask

  // Write all eight registers; only call while idle.
  task automatic load_setup(logic [CFG_W-1:0] x_mode, logic [CFG_W-1:0] r_trim,
                            logic [CFG_W-1:0] p_trim, logic [CFG_W-1:0] y_trim,
                            logic [CFG_W-1:0] gains, logic [CFG_W-1:0] floor_val,
                            logic [CFG_W-1:0] ovr_on, logic [CFG_W-1:0] ovr_lvls);
    write_reg(REG_X_FORMATION,     with_junk(x_mode, 1));
    write_reg(REG_ROLL_TRIM,       with_junk(r_trim, TRIM_W));
    write_reg(REG_PITCH_TRIM,      with_junk(p_trim, TRIM_W));
    write_reg(REG_YAW_TRIM,        with_junk(y_trim, TRIM_W));
    write_reg(REG_MOTOR_GAINS,     gains);
    write_reg(REG_IDLE_FLOOR,      with_junk(floor_val, LEVEL_W));
    write_reg(REG_OVERRIDE_ON,     with_junk(ovr_on, 1));
    write_reg(REG_OVERRIDE_LEVELS, ovr_lvls);
  endtask

  function automatic cmd_t make_cmd(int roll, int pitch, int yaw, int thrust);
    cmd_t c;
    c.roll_cmd   = CMD_W'(roll);
    c.pitch_cmd  = CMD_W'(pitch);
    c.yaw_cmd    = CMD_W'(yaw);
    c.thrust_cmd = CMD_W'(thrust);
    return c;
  endfunction

  function automatic logic [CMD_W-1:0] edge_value();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Realistic attitude commands half the time, plus full-range noise and corners.
  function automatic cmd_t rand_cmd();
    cmd_t c;
    case ($urandom_range(0, 3))
      0: begin
        c = cmd_t'({$urandom, $urandom});
      end
      1: begin
        c.roll_cmd   = edge_value();
        c.pitch_cmd  = edge_value();
        c.yaw_cmd    = edge_value();
        c.thrust_cmd = edge_value();
      end
      default: begin
        c = make_cmd(int'($urandom_range(0, 4000)) - 2000,
                     int'($urandom_range(0, 4000)) - 2000,
                     int'($urandom_range(0, 4000)) - 2000,
                     int'($urandom_range(0, 65535)));
      end
    endcase
    return c;
  endfunction

  function automatic logic [TRIM_W-1:0] rand_trim();
    if ($urandom_range(0, 3) == 0) return TRIM_W'($urandom);
    return TRIM_W'(int'($urandom_range(0, 16383)) - 8192);
  endfunction

  function automatic logic [CFG_W-1:0] rand_gains();
    logic [CFG_W-1:0] g;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 3) == 0) g[GAIN_W*k +: GAIN_W] = GAIN_W'($urandom);
      else g[GAIN_W*k +: GAIN_W] = GAIN_W'($urandom_range(16'h3000, 16'h5000));
    end
    return g;
  endfunction

  // Idle in bursts: mostly none, one time in four a random nonzero gap.
  function automatic int rand_gap();
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(1, 19));
    return 0;
  endfunction

  task automatic random_setup(setup_kind_e kind);
    case (kind)
      SETUP_LOW:
        load_setup(1, -8388608, -8388608, -8388608, rand_gains(), 0, 0,
                   {$urandom, $urandom});
      SETUP_HIGH:
        load_setup(0, 8388607, 8388607, 8388607, 64'hFFFF_FFFF_FFFF_FFFF,
                   $urandom_range(0, 65535), 0, {$urandom, $urandom});
      default:
        load_setup($urandom_range(0, 1), rand_trim(), rand_trim(), rand_trim(),
                   rand_gains(),
                   ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 2000),
                   ($urandom_range(0, 5) == 0), {$urandom, $urandom});
    endcase
  endtask

  // Plus mixing with reset registers: zero, full thrust, saturation both ways.
  task automatic test_plus_mix();
    send_cmd(make_cmd(0, 0, 0, 0), 0);
    send_cmd(make_cmd(0, 0, 0, 65535), 0);
    send_cmd(make_cmd(32767, 32767, 32767, 65535), 0);
    send_cmd(make_cmd(-32768, -32768, -32768, 0), 0);
    send_cmd(make_cmd(100, -200, 300, 1000), 0);
    settle();
  endtask

  // X mixing: halving must truncate toward zero, including fractional trims.
  task automatic test_x_mix();
    load_setup(1, 128, -128, 0, GAINS_RESET, 0, 0, 0);
    send_cmd(make_cmd(1, -1, 0, 1000), 0);
    send_cmd(make_cmd(3, -3, 5, 1000), 0);
    send_cmd(make_cmd(-32768, 32767, -32768, 65535), 0);
    send_cmd(make_cmd(32767, -32768, 32767, 0), 0);
    settle();
    // trims at their extremes
    load_setup(1, 8388607, -8388608, 8388607, GAINS_RESET, 0, 0, 0);
    send_cmd(make_cmd(-1, 1, -1, 30000), 0);
    send_cmd(make_cmd(32767, -32768, 0, 65535), 0);
    settle();
  endtask

  // Gain extremes give fractional products; then raise the floor to the top.
  task automatic test_gain_floor();
    load_setup(0, 128, 128, -128, 64'h2000_0000_0001_FFFF, 300, 0, 0);
    send_cmd(make_cmd(0, 0, 0, 20000), 0);
    send_cmd(make_cmd(-5, 7, -9, 100), 0);
    send_cmd(make_cmd(0, 0, 0, 65535), 0);
    settle();
    load_setup(0, 0, 0, 0, GAINS_RESET, 65535, 0, 0);
    send_cmd(make_cmd(-32768, 32767, 32767, 0), 0);
    settle();
  endtask

  // Override passes fixed levels through with no floor; then turn it off.
  task automatic test_override();
    load_setup(1, 0, 0, 0, GAINS_RESET, 65535, 1, 64'h0000_FFFF_1234_8001);
    send_cmd(make_cmd(32767, 32767, 32767, 65535), 0);
    send_cmd(make_cmd(-32768, -32768, -32768, 0), 0);
    settle();
    load_setup(0, 0, 0, 0, GAINS_RESET, 50, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(make_cmd(10, -10, 20, 40), 0);
    settle();
  endtask

  // Random phases, each with a fresh setup and a full drain before the next.
  // Close with a back-to-back stretch with no idling at all.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 1) random_setup(SETUP_LOW);
      else if (phase == 2) random_setup(SETUP_HIGH);
      else random_setup(SETUP_RANDOM);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_cmd(rand_cmd(), rand_gap());
      end
      settle();
    end
    random_setup(SETUP_RANDOM);
    for (int n = 0; n < STREAM_ITEMS; n++) begin
      send_cmd(rand_cmd(), 0);
    end
    settle();
  endtask

  initial begin
    // hold reset, then release on a falling edge
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    test_plus_mix();
    test_x_mix();
    test_gain_floor();
    test_override();
    test_random_traffic();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
